// ----- hdl/assert_macros.svh -----
// Assertion macros used by the top level of the stack machine executor.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define SME_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Consequent checked in the cycle after the antecedent holds.
`define SME_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/sme_pkg.sv -----
// Types and constants shared by the stack machine executor modules.
package sme_pkg;

    localparam logic [3:0] CMD_PUSH    = 4'd0;
    localparam logic [3:0] CMD_ADD     = 4'd1;
    localparam logic [3:0] CMD_SUB     = 4'd2;
    localparam logic [3:0] CMD_MUL     = 4'd3;
    localparam logic [3:0] CMD_DIV     = 4'd4;
    localparam logic [3:0] CMD_MOD     = 4'd5;
    localparam logic [3:0] CMD_EQ      = 4'd6;
    localparam logic [3:0] CMD_GR      = 4'd7;
    localparam logic [3:0] CMD_DUP     = 4'd8;
    localparam logic [3:0] CMD_SWAP    = 4'd9;
    localparam logic [3:0] CMD_CJMP    = 4'd10;
    localparam logic [3:0] CMD_PRINT   = 4'd11;
    localparam logic [3:0] CMD_NEWLINE = 4'd12;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_UNDER = 2'd1;
    localparam logic [1:0] STAT_OVER  = 2'd2;
    localparam logic [1:0] STAT_DIVZ  = 2'd3;

    typedef struct packed {
        logic [3:0]         command;
        logic signed [31:0] push_value;
        logic [15:0]        current_pc;
    } t_sme_in;

    typedef struct packed {
        logic [1:0]         status;
        logic [15:0]        next_pc;
        logic               print_valid;
        logic signed [31:0] print_value;
        logic               newline_flag;
    } t_sme_out;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SWAP,
        S_WAIT
    } t_state;

    typedef enum logic [1:0] {
        IT_MUL,
        IT_DIV,
        IT_MOD
    } t_iter_op;

    typedef struct packed {
        logic     start;
        t_iter_op op;
    } t_iter_req;

endpackage

// ----- hdl/sme_ram.sv -----
// Generic single-write, dual-read RAM with registered read data.
module sme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ----- hdl/sme_iter.sv -----
// Iterative multiplier (16 bits a step) and restoring divider (one bit a step).
module sme_iter #(
    parameter int WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sme_pkg::t_iter_req i_req,
    input  logic [WIDTH-1:0]  i_a,
    input  logic [WIDTH-1:0]  i_b,
    output logic              o_done,
    output logic [WIDTH-1:0]  o_result
);
    import sme_pkg::*;

    localparam int NCH  = (WIDTH + 15) / 16;
    localparam int CNTW = $clog2(WIDTH + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNTW-1:0]  r_cnt;
    t_iter_op         r_op;
    logic [WIDTH-1:0] r_a;
    logic [WIDTH-1:0] r_b;
    logic [WIDTH-1:0] r_acc;
    logic             r_nega;
    logic             r_negq;

    logic [15:0]       w_chunk;
    logic [WIDTH+15:0] w_prod;
    logic [WIDTH:0]    w_rem_sh;
    logic [WIDTH:0]    w_diff;
    logic [WIDTH-1:0]  w_ma;
    logic [WIDTH-1:0]  w_mb;

    assign w_chunk  = 16'(r_b);
    assign w_prod   = r_a * w_chunk;
    assign w_rem_sh = {r_acc, r_a[WIDTH-1]};
    assign w_diff   = w_rem_sh - {1'b0, r_b};
    assign w_ma     = i_a[WIDTH-1] ? (WIDTH'(0) - i_a) : i_a;
    assign w_mb     = i_b[WIDTH-1] ? (WIDTH'(0) - i_b) : i_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= (i_req.op == IT_MUL) ? CNTW'(NCH) : CNTW'(WIDTH);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNTW'(1);
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // For division r_a holds the dividend shifting out and the quotient shifting in,
    // and r_acc holds the partial remainder.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_op   <= i_req.op;
            r_nega <= i_a[WIDTH-1];
            r_negq <= i_a[WIDTH-1] ^ i_b[WIDTH-1];
            r_acc  <= '0;
            if (i_req.op == IT_MUL) begin
                r_a <= i_a;
                r_b <= i_b;
            end else begin
                r_a <= w_ma;
                r_b <= w_mb;
            end
        end else if (r_busy) begin
            if (r_op == IT_MUL) begin
                r_acc <= r_acc + w_prod[WIDTH-1:0];
                r_a   <= r_a << 16;
                r_b   <= r_b >> 16;
            end else begin
                if (!w_diff[WIDTH]) begin
                    r_acc <= w_diff[WIDTH-1:0];
                    r_a   <= {r_a[WIDTH-2:0], 1'b1};
                end else begin
                    r_acc <= w_rem_sh[WIDTH-1:0];
                    r_a   <= {r_a[WIDTH-2:0], 1'b0};
                end
            end
        end
    end

    always_comb begin
        case (r_op)
            IT_MUL:  o_result = r_acc;
            IT_DIV:  o_result = r_negq ? (WIDTH'(0) - r_a) : r_a;
            IT_MOD:  o_result = r_nega ? (WIDTH'(0) - r_acc) : r_acc;
            default: o_result = r_acc;
        endcase
    end

    assign o_done = r_done;

endmodule

// ----- hdl/stack_machine_executor_top.sv -----
// Stack machine executor top level: one instruction per item on a RAM-held stack.
// Most commands register their result from the execute state after acceptance; swap adds a
// second write state (two writes through the single RAM write port), and mul, div and mod
// wait for the iterative unit; busy is low in the strobe cycle, so the next item may be
// accepted at the edge that takes the result, but none is taken while busy. Synchronous
// active-low reset empties the stack; results cannot stall.
module stack_machine_executor_top #(
    parameter int STACK_DEPTH = 64,
    parameter int WORD_WIDTH  = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  sme_pkg::t_sme_in  i_cmd,
    output logic              o_valid,
    output sme_pkg::t_sme_out o_result
);
    import sme_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int XW = (WORD_WIDTH > 16) ? WORD_WIDTH : 16;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    t_sme_in         r_in;
    t_sme_out        r_out, n_out;
    logic            r_valid, n_valid;

    logic                  w_accept;
    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    logic [WORD_WIDTH-1:0] w_wdata;
    logic [CW-1:0]         w_cm1;
    logic [CW-1:0]         w_cm2;
    logic [AW-1:0]         w_idx_top;
    logic [AW-1:0]         w_idx_sec;
    logic [AW-1:0]         w_idx_push;
    logic [WORD_WIDTH-1:0] w_a;
    logic [WORD_WIDTH-1:0] w_b;
    logic [WORD_WIDTH-1:0] w_pv;
    logic [XW-1:0]         w_b_sx;
    logic [15:0]           w_jmp;
    logic                  w_empty;
    logic                  w_lt2;
    logic                  w_full;
    t_iter_req             n_ireq;
    logic                  w_it_done;
    logic [WORD_WIDTH-1:0] w_it_res;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;

    assign w_cm1      = r_count - CW'(1);
    assign w_cm2      = r_count - CW'(2);
    assign w_idx_top  = w_cm1[AW-1:0];
    assign w_idx_sec  = w_cm2[AW-1:0];
    assign w_idx_push = r_count[AW-1:0];

    assign w_empty = (r_count == '0);
    assign w_lt2   = (r_count < CW'(2));
    assign w_full  = (r_count >= CW'(STACK_DEPTH));

    assign w_pv   = WORD_WIDTH'($signed(r_in.push_value));
    assign w_b_sx = XW'($signed(w_b));
    assign w_jmp  = r_in.current_pc + w_b_sx[15:0] - 16'd1;

    sme_ram #(
        .WIDTH(WORD_WIDTH),
        .DEPTH(STACK_DEPTH)
    ) u_stack (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_re      (w_accept),
        .i_raddr_a (w_idx_top),
        .i_raddr_b (w_idx_sec),
        .o_rdata_a (w_b),
        .o_rdata_b (w_a)
    );

    sme_iter #(
        .WIDTH(WORD_WIDTH)
    ) u_iter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (n_ireq),
        .i_a      (w_a),
        .i_b      (w_b),
        .o_done   (w_it_done),
        .o_result (w_it_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_cmd;
        end
        if (n_valid) begin
            r_out <= n_out;
        end
    end

    // The top of stack reads on port a (operand B), the word below it on port b (operand A).
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_valid      = 1'b0;
        n_out        = '0;
        n_out.status = STAT_OK;
        n_out.next_pc = r_in.current_pc;
        n_ireq       = '{start: 1'b0, op: IT_MUL};
        w_we         = 1'b0;
        w_waddr      = w_idx_sec;
        w_wdata      = w_a;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_valid = 1'b1;
                n_state = S_IDLE;
                case (r_in.command)
                    CMD_PUSH: begin
                        if (w_full) begin
                            n_out.status = STAT_OVER;
                        end else begin
                            w_we    = 1'b1;
                            w_waddr = w_idx_push;
                            w_wdata = w_pv;
                            n_count = r_count + CW'(1);
                        end
                    end
                    CMD_ADD, CMD_SUB, CMD_EQ, CMD_GR: begin
                        if (w_lt2) begin
                            n_out.status = STAT_UNDER;
                        end else begin
                            w_we    = 1'b1;
                            n_count = w_cm1;
                            case (r_in.command)
                                CMD_ADD: w_wdata = w_a + w_b;
                                CMD_SUB: w_wdata = w_a - w_b;
                                CMD_EQ:  w_wdata = WORD_WIDTH'(w_a == w_b);
                                default: w_wdata = WORD_WIDTH'($signed(w_a) > $signed(w_b));
                            endcase
                        end
                    end
                    CMD_MUL, CMD_DIV, CMD_MOD: begin
                        if (w_lt2) begin
                            n_out.status = STAT_UNDER;
                        end else if (r_in.command != CMD_MUL && w_b == '0) begin
                            n_out.status = STAT_DIVZ;
                        end else begin
                            n_valid      = 1'b0;
                            n_state      = S_WAIT;
                            n_ireq.start = 1'b1;
                            case (r_in.command)
                                CMD_MUL: n_ireq.op = IT_MUL;
                                CMD_DIV: n_ireq.op = IT_DIV;
                                default: n_ireq.op = IT_MOD;
                            endcase
                        end
                    end
                    CMD_DUP: begin
                        if (w_empty) begin
                            n_out.status = STAT_UNDER;
                        end else if (w_full) begin
                            n_out.status = STAT_OVER;
                        end else begin
                            w_we    = 1'b1;
                            w_waddr = w_idx_push;
                            w_wdata = w_b;
                            n_count = r_count + CW'(1);
                        end
                    end
                    CMD_SWAP: begin
                        if (w_lt2) begin
                            n_out.status = STAT_UNDER;
                        end else begin
                            // The second word goes on top now; the old top lands next cycle.
                            w_we    = 1'b1;
                            w_waddr = w_idx_top;
                            w_wdata = w_a;
                            n_valid = 1'b0;
                            n_state = S_SWAP;
                        end
                    end
                    CMD_CJMP: begin
                        if (w_lt2) begin
                            n_out.status = STAT_UNDER;
                        end else begin
                            n_count = w_cm2;
                            if (w_a != '0) begin
                                n_out.next_pc = w_jmp;
                            end
                        end
                    end
                    CMD_PRINT: begin
                        if (w_empty) begin
                            n_out.status = STAT_UNDER;
                        end else begin
                            n_out.print_valid = 1'b1;
                            n_out.print_value = 32'($signed(w_b));
                            n_count           = w_cm1;
                        end
                    end
                    CMD_NEWLINE: begin
                        n_out.newline_flag = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            S_SWAP: begin
                w_we    = 1'b1;
                w_waddr = w_idx_sec;
                w_wdata = w_b;
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            S_WAIT: begin
                if (w_it_done) begin
                    w_we    = 1'b1;
                    w_waddr = w_idx_sec;
                    w_wdata = w_it_res;
                    n_count = w_cm1;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_valid  = r_valid;
    assign o_result = r_out;

`include "assert_macros.svh"

    `SME_ASSERT(a_count_bound, r_count <= CW'(STACK_DEPTH), "stack count above depth")
    `SME_ASSERT_NEXT(a_strobe_single, o_valid, !o_valid, "result strobe longer than a cycle")
    `SME_ASSERT(a_write_busy, !w_we || busy, "stack written while idle")
    `SME_ASSERT_NEXT(a_accept_exec, w_accept, r_state == S_EXEC, "accepted item not executed")

endmodule
